// ----- rtl/core/hta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hole table allocator package
// Shared widths, command and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned AlignW  = 21;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ModCntW = 6;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK     = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NO_MEM = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ALC_LOAD,
    S_ALC_TEST,
    S_ALC_MOD,
    S_ALC_CHECK,
    S_ALC_FIT,
    S_ALC_PREV,
    S_FRE_SPARE,
    S_FRE_LOAD,
    S_FRE_INS,
    S_CO_CHK,
    S_CO_LOAD,
    S_CO_CMP,
    S_CO_WX,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/hta_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hole table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hta_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 103
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/hta_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring remainder of a 48-bit base by the alignment, one bit per cycle.
// ----------------------------------------------------------------------------
module hta_mod
  import hta_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [AddrW-1:0]  dividend_i,
  input  wire logic [AlignW-1:0] divisor_i,
  output logic                   done_o,
  output logic      [AlignW-1:0] rem_o
);

  logic               run_q;
  logic               done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [AddrW-1:0]   dvd_q;
  logic [AlignW-1:0]  rem_q;
  logic [AlignW:0]    trial;
  logic [AlignW:0]    step;

  // Bring down the next bit and subtract the divisor when it fits.
  assign trial = {rem_q, dvd_q[AddrW-1]};
  assign step  = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= ModCntW'(AddrW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[AddrW-2:0], 1'b0};
      rem_q <= step[AlignW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/hole_table_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Operation: an allocate loads and tests each hole in turn, passing over one too small for
// the length; a hole tested without padding goes straight to the fit check, and one that
// needs padding first runs the serial remainder, then the fit is written back and the word
// handed over. A free fetches a spare slot, walks the list to the insertion point, inserts,
// coalesces and hands the word over. One command at a time. Reset: after rst_ni is released,
// a clearing pass writes every table entry, one per cycle, before the first word is accepted.
// ----------------------------------------------------------------------------
// Hole table allocator
// First-fit range allocator over an address-sorted linked list of holes in memory.
// ----------------------------------------------------------------------------
module hole_table_allocator_top
  import hta_pkg::*;
#(
  parameter int unsigned HOLE_COUNT = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // length[47:0], alignment[68:48], address[116:69], zero fill [119:117]
  input  wire logic [119:0] s_axis_tdata_i,
  // command[0]
  input  wire logic         s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // granted_address[47:0], status[49:48], zero fill [55:50]
  output logic      [55:0]  m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(HOLE_COUNT);
  localparam int unsigned LW = $clog2(HOLE_COUNT + 1);
  localparam int unsigned EW = 2 * AddrW + LW;
  localparam logic [LW-1:0] NilLink = LW'(HOLE_COUNT);

  state_e state_q, state_d;

  logic [LW-1:0] head_q, spare_q;
  logic [IW-1:0] init_cnt_q;
  logic          round_q;
  logic          prv_valid_q;

  logic [AddrW-1:0]  len_q, addr_q;
  logic [AlignW-1:0] align_q, pad_q;

  logic [LW-1:0]    cur_idx_q, cur_link_q, prv_idx_q, prv_link_q, nw_idx_q, nw_link_q;
  logic [AddrW-1:0] cur_base_q, cur_size_q, prv_base_q, prv_size_q, nw_base_q, nw_size_q;
  logic [LW-1:0]    rd_idx_q;

  logic [AddrW-1:0]   res_addr_q, out_addr_q;
  logic [StatusW-1:0] res_status_q, out_status_q;
  logic               out_valid_q;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic [AddrW-1:0] rd_base, rd_size;
  logic [LW-1:0]    rd_link;
  assign {rd_link, rd_size, rd_base} = rd_data;

  logic in_fire, out_free;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  logic [AddrW-1:0]  in_len, in_addr;
  logic [AlignW-1:0] in_align;
  assign in_len   = s_axis_tdata_i[47:0];
  assign in_align = s_axis_tdata_i[68:48];
  assign in_addr  = s_axis_tdata_i[116:69];

  // Datapath conditions.
  logic             mod_start, mod_done;
  logic [AlignW-1:0] mod_rem;
  logic [AlignW-1:0] pad_calc;
  logic [AddrW:0]    need;
  logic              alc_small, alc_fits, fit_empty, prev_touch, fre_stop, co_touch;
  logic [AddrW-1:0]  got, new_base, new_size;

  assign pad_calc   = (mod_rem == '0) ? '0 : align_q - mod_rem;
  assign need       = {1'b0, len_q} + {{(AddrW - AlignW + 1){1'b0}}, pad_q};
  assign alc_small  = cur_size_q < len_q;
  assign alc_fits   = {1'b0, cur_size_q} >= need;
  assign got        = cur_base_q + {{(AddrW - AlignW){1'b0}}, pad_q};
  assign new_base   = cur_base_q + need[AddrW-1:0];
  assign new_size   = cur_size_q - need[AddrW-1:0];
  assign fit_empty  = new_size == '0;
  assign prev_touch = prv_valid_q && ((prv_base_q + prv_size_q) == got);
  assign fre_stop   = addr_q <= rd_base;
  assign co_touch   = (nw_base_q + nw_size_q) == cur_base_q;

  hta_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(cur_base_q),
    .divisor_i (align_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  hta_ram #(
    .Depth(HOLE_COUNT),
    .Width(EW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Next state, memory ports and handshakes.
  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    mod_start = 1'b0;
    unique case (state_q)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_cnt_q;
        wr_data = {LW'(init_cnt_q) + 1'b1, {AddrW{1'b0}}, {AddrW{1'b0}}};
        if (init_cnt_q == IW'(HOLE_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == CMD_ALLOC) begin
            if (head_q == NilLink) begin
              state_d = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q[IW-1:0];
              state_d = S_ALC_LOAD;
            end
          end else if (in_len == '0 || spare_q == NilLink) begin
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = spare_q[IW-1:0];
            state_d = S_FRE_SPARE;
          end
        end
      end
      S_ALC_LOAD: state_d = S_ALC_TEST;
      S_ALC_TEST: begin
        if (alc_small) begin
          if (cur_link_q == NilLink) begin
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cur_link_q[IW-1:0];
            state_d = S_ALC_LOAD;
          end
        end else if (align_q <= AlignW'(1)) begin
          state_d = S_ALC_CHECK;
        end else begin
          mod_start = 1'b1;
          state_d   = S_ALC_MOD;
        end
      end
      S_ALC_MOD: begin
        if (mod_done) state_d = S_ALC_CHECK;
      end
      S_ALC_CHECK: begin
        if (alc_fits) begin
          state_d = S_ALC_FIT;
        end else if (cur_link_q == NilLink) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_link_q[IW-1:0];
          state_d = S_ALC_LOAD;
        end
      end
      S_ALC_FIT: begin
        wr_en   = 1'b1;
        wr_addr = cur_idx_q[IW-1:0];
        wr_data = fit_empty ? {spare_q, {AddrW{1'b0}}, {AddrW{1'b0}}}
                            : {cur_link_q, new_size, new_base};
        state_d = prv_valid_q ? S_ALC_PREV : S_DONE;
      end
      S_ALC_PREV: begin
        wr_en   = 1'b1;
        wr_addr = prv_idx_q[IW-1:0];
        wr_data = {prv_link_q, prv_size_q, prv_base_q};
        state_d = S_DONE;
      end
      S_FRE_SPARE: begin
        if (head_q == NilLink) begin
          state_d = S_CO_CHK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q[IW-1:0];
          state_d = S_FRE_LOAD;
        end
      end
      S_FRE_LOAD: begin
        if (fre_stop) begin
          state_d = prv_valid_q ? S_FRE_INS : S_CO_CHK;
        end else if (rd_link == NilLink) begin
          state_d = S_FRE_INS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_link[IW-1:0];
        end
      end
      S_FRE_INS: begin
        wr_en   = 1'b1;
        wr_addr = nw_idx_q[IW-1:0];
        wr_data = {nw_link_q, nw_size_q, nw_base_q};
        state_d = S_CO_CHK;
      end
      S_CO_CHK: begin
        if (nw_link_q == NilLink) begin
          state_d = S_CO_WX;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nw_link_q[IW-1:0];
          state_d = S_CO_LOAD;
        end
      end
      S_CO_LOAD: state_d = S_CO_CMP;
      S_CO_CMP: begin
        wr_en = 1'b1;
        if (co_touch) begin
          wr_addr = cur_idx_q[IW-1:0];
          wr_data = {spare_q, {AddrW{1'b0}}, {AddrW{1'b0}}};
          state_d = round_q ? S_CO_WX : S_CO_CHK;
        end else begin
          wr_addr = nw_idx_q[IW-1:0];
          wr_data = {nw_link_q, nw_size_q, nw_base_q};
          state_d = round_q ? S_DONE : S_CO_CHK;
        end
      end
      S_CO_WX: begin
        wr_en   = 1'b1;
        wr_addr = nw_idx_q[IW-1:0];
        wr_data = {nw_link_q, nw_size_q, nw_base_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready_o = state_q == S_IDLE;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      head_q      <= NilLink;
      spare_q     <= '0;
      init_cnt_q  <= '0;
      round_q     <= 1'b0;
      prv_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT) init_cnt_q <= init_cnt_q + 1'b1;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          prv_valid_q <= 1'b0;
          round_q     <= 1'b0;
        end
        S_ALC_TEST: if (alc_small) prv_valid_q <= 1'b1;
        S_ALC_CHECK: if (!alc_fits) prv_valid_q <= 1'b1;
        S_ALC_FIT: begin
          if (fit_empty) begin
            spare_q <= cur_idx_q;
            if (!prv_valid_q) head_q <= cur_link_q;
          end
        end
        S_FRE_SPARE: begin
          spare_q <= rd_link;
          if (head_q == NilLink) head_q <= spare_q;
        end
        S_FRE_LOAD: begin
          if (fre_stop && !prv_valid_q) head_q <= nw_idx_q;
          if (!fre_stop) prv_valid_q <= 1'b1;
        end
        S_CO_CMP: begin
          round_q <= 1'b1;
          if (co_touch) spare_q <= cur_idx_q;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_idx_q <= LW'(rd_addr);
    if (state_q == S_DONE && out_free) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
    unique case (state_q)
      S_IDLE: begin
        len_q      <= in_len;
        align_q    <= in_align;
        addr_q     <= in_addr;
        pad_q      <= '0;
        res_addr_q <= '0;
        if (s_axis_tuser_i == CMD_ALLOC && head_q == NilLink) begin
          res_status_q <= STATUS_NO_MEM;
        end else if (s_axis_tuser_i == CMD_FREE && in_len != '0 && spare_q == NilLink) begin
          res_status_q <= STATUS_FULL;
        end else begin
          res_status_q <= STATUS_OK;
        end
      end
      S_ALC_LOAD, S_CO_LOAD: begin
        cur_idx_q  <= rd_idx_q;
        cur_base_q <= rd_base;
        cur_size_q <= rd_size;
        cur_link_q <= rd_link;
        pad_q      <= '0;
      end
      S_ALC_TEST, S_ALC_CHECK: begin
        if ((state_q == S_ALC_TEST && alc_small) || (state_q == S_ALC_CHECK && !alc_fits)) begin
          prv_idx_q  <= cur_idx_q;
          prv_base_q <= cur_base_q;
          prv_size_q <= cur_size_q;
          prv_link_q <= cur_link_q;
          if (cur_link_q == NilLink) res_status_q <= STATUS_NO_MEM;
        end
      end
      S_ALC_MOD: if (mod_done) pad_q <= pad_calc;
      S_ALC_FIT: begin
        res_addr_q <= got;
        if (prev_touch) prv_size_q <= prv_size_q + {{(AddrW - AlignW){1'b0}}, pad_q};
        if (fit_empty && prv_valid_q) prv_link_q <= cur_link_q;
      end
      S_FRE_SPARE: begin
        nw_idx_q  <= spare_q;
        nw_base_q <= addr_q;
        nw_size_q <= len_q;
        nw_link_q <= head_q;
      end
      S_FRE_LOAD: begin
        if (fre_stop) begin
          if (prv_valid_q) begin
            nw_link_q  <= prv_link_q;
            prv_link_q <= nw_idx_q;
          end else begin
            nw_link_q <= rd_idx_q;
          end
        end else begin
          prv_idx_q  <= rd_idx_q;
          prv_base_q <= rd_base;
          prv_size_q <= rd_size;
          if (rd_link == NilLink) begin
            nw_link_q  <= rd_link;
            prv_link_q <= nw_idx_q;
          end else begin
            prv_link_q <= rd_link;
          end
        end
      end
      S_FRE_INS: begin
        nw_idx_q  <= prv_idx_q;
        nw_base_q <= prv_base_q;
        nw_size_q <= prv_size_q;
        nw_link_q <= prv_link_q;
      end
      S_CO_CMP: begin
        if (co_touch) begin
          nw_size_q <= nw_size_q + cur_size_q;
          nw_link_q <= cur_link_q;
        end else begin
          nw_idx_q  <= cur_idx_q;
          nw_base_q <= cur_base_q;
          nw_size_q <= cur_size_q;
          nw_link_q <= cur_link_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q, out_addr_q};

endmodule
`default_nettype wire
